### rtl/pdtd_pkg.sv
// shared types and constants of the pixel defect track debouncer
package pdtd_pkg;

    // fixed field widths
    localparam int FRAME_W     = 31;
    localparam int OUT_COORD_W = 14;
    localparam int PERSIST_W   = 16;
    localparam int QUIET_W     = 32;
    localparam int GAP_W       = 16;
    localparam int RADIUS_W    = 8;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [PERSIST_W-1:0] PERSIST_MAX = '1;

    // request operation codes
    localparam logic OP_CLEAR = 1'b1;

    // register indexes
    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_MIN_PERSIST = 2'd0;
    localparam reg_idx_t REG_MAX_GAP     = 2'd1;
    localparam reg_idx_t REG_COOLDOWN    = 2'd2;
    localparam reg_idx_t REG_RADIUS      = 2'd3;

    // register reset values
    localparam logic [PERSIST_W-1:0] RST_MIN_PERSIST = 16'd3;
    localparam logic [GAP_W-1:0]     RST_MAX_GAP     = 16'd1;
    localparam logic [GAP_W-1:0]     RST_COOLDOWN    = 16'd0;
    localparam logic [RADIUS_W-1:0]  RST_RADIUS      = 8'd0;

    typedef struct packed {
        logic [PERSIST_W-1:0] min_persistence;
        logic [GAP_W-1:0]     max_gap_frames;
        logic [GAP_W-1:0]     cooldown_frames;
        logic [RADIUS_W-1:0]  merge_radius;
    } cfg_t;

endpackage

### rtl/pixel_defect_track_debouncer.sv
// top level of the pixel defect track debouncer: sequencer, track table and config
//
// A hit request is taken when start is high and busy is low. The block then walks
// the track table one slot per clock through the single read port of the track
// memory, feeding each key into a shared three-stage squared distance pipeline,
// and busy stays high until the hit is through, so no new request is taken while
// it is in work. A clear request empties the table without leaving the idle state.
// Each request produces exactly one result, shown on the result ports for a
// single cycle with done high; the receiver cannot stall it, so it must take the
// result in that cycle. Configuration must be written over the apb port only
// while the block is idle; the block itself does not enforce this.
module pixel_defect_track_debouncer
    import pdtd_pkg::*;
#(
    parameter int TRACK_SLOTS = 64,
    parameter int COORD_BITS  = 14
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    input  logic                   start,
    output logic                   busy,
    input  logic                   operation,
    input  logic [FRAME_W-1:0]     frame_index,
    input  logic [OUT_COORD_W-1:0] hit_x,
    input  logic [OUT_COORD_W-1:0] hit_y,
    output logic                   done,
    output logic                   event_fired,
    output logic [FRAME_W-1:0]     event_frame,
    output logic [OUT_COORD_W-1:0] event_x,
    output logic [OUT_COORD_W-1:0] event_y,
    output logic [OUT_COORD_W-1:0] track_x,
    output logic [OUT_COORD_W-1:0] track_y,
    output logic [PERSIST_W-1:0]   persistence,
    output logic                   dropped
);

    localparam int CB    = COORD_BITS;
    localparam int IDX_W = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
    localparam int D_W   = 2 * CB + 1;
    localparam int TAG_W = 2 + IDX_W + 2 * CB;
    localparam int MEM_W = 2 * CB + FRAME_W + PERSIST_W + QUIET_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TRACK_SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FETCH,
        S_UPD1,
        S_UPD2
    } state_t;

    cfg_t cfg;

    state_t                   state_reg;
    logic [TRACK_SLOTS-1:0]   valid_reg;
    logic [FRAME_W-1:0]       frame_reg;
    logic [CB-1:0]            x_reg, y_reg;
    logic [2*RADIUS_W-1:0]    rsq_reg;
    logic [IDX_W-1:0]         scan_idx_reg;
    logic                     iss_vld_reg, iss_last_reg, iss_ent_reg;
    logic [IDX_W-1:0]         iss_idx_reg;
    logic                     best_found_reg;
    logic [D_W-1:0]           best_d_reg;
    logic [IDX_W-1:0]         best_idx_reg;
    logic [CB-1:0]            best_kc_reg, best_kr_reg;
    logic                     free_found_reg;
    logic [IDX_W-1:0]         free_idx_reg;
    logic [IDX_W-1:0]         slot_reg;
    logic [CB-1:0]            kc_reg, kr_reg;
    logic [PERSIST_W-1:0]     cnt_reg;
    logic [QUIET_W-1:0]       quiet_reg;

    logic                     done_reg, fired_reg, dropped_reg;
    logic [FRAME_W-1:0]       ev_frame_reg;
    logic [OUT_COORD_W-1:0]   ev_x_reg, ev_y_reg, trk_x_reg, trk_y_reg;
    logic [PERSIST_W-1:0]     pers_reg;

    logic                     accept;
    logic [IDX_W-1:0]         rd_addr;
    logic [MEM_W-1:0]         rd_data;
    logic                     wr_en;
    logic [MEM_W-1:0]         wr_data;

    logic [CB-1:0]            rd_kc, rd_kr;
    logic [FRAME_W-1:0]       rd_last;
    logic [PERSIST_W-1:0]     rd_cnt;
    logic [QUIET_W-1:0]       rd_quiet;

    logic                     d_vld;
    logic [TAG_W-1:0]         d_tag;
    logic [D_W-1:0]           d_dist;
    logic                     o_last, o_ent;
    logic [IDX_W-1:0]         o_idx;
    logic [CB-1:0]            o_kc, o_kr;
    logic                     cand_better;

    logic                     frame_gt;
    logic [FRAME_W-1:0]       gap;
    logic [FRAME_W:0]         gap_lim;
    logic                     gap_ok;
    logic [PERSIST_W-1:0]     cnt_upd;
    logic [PERSIST_W-1:0]     min_p;
    logic                     fire;
    logic [QUIET_W-1:0]       quiet_new;

    // configuration registers
    pdtd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // track table
    pdtd_track_mem #(
        .DEPTH  (TRACK_SLOTS),
        .DATA_W (MEM_W),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // shared distance pipeline
    pdtd_dist_unit #(
        .COORD_W (CB),
        .TAG_W   (TAG_W)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (iss_vld_reg),
        .in_tag   ({iss_last_reg, iss_ent_reg, iss_idx_reg, rd_kc, rd_kr}),
        .key_col  (rd_kc),
        .key_row  (rd_kr),
        .pos_x    (x_reg),
        .pos_y    (y_reg),
        .out_vld  (d_vld),
        .out_tag  (d_tag),
        .out_dist (d_dist)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // memory access
    assign rd_addr = (state_reg == S_SCAN) ? scan_idx_reg : best_idx_reg;
    assign wr_en   = (state_reg == S_UPD2);
    assign wr_data = {kc_reg, kr_reg, frame_reg, cnt_reg, quiet_new};

    // unpack the stored entry
    assign rd_kc    = rd_data[MEM_W-1 -: CB];
    assign rd_kr    = rd_data[MEM_W-1-CB -: CB];
    assign rd_last  = rd_data[QUIET_W+PERSIST_W +: FRAME_W];
    assign rd_cnt   = rd_data[QUIET_W +: PERSIST_W];
    assign rd_quiet = rd_data[0 +: QUIET_W];

    // unpack the pipeline tag
    assign o_last = d_tag[TAG_W-1];
    assign o_ent  = d_tag[TAG_W-2];
    assign o_idx  = d_tag[2*CB +: IDX_W];
    assign o_kc   = d_tag[CB +: CB];
    assign o_kr   = d_tag[0 +: CB];

    // nearest candidate selection, ties to the smallest key
    assign cand_better = d_vld && o_ent && (d_dist <= D_W'(rsq_reg)) &&
                         (!best_found_reg || (d_dist < best_d_reg) ||
                          ((d_dist == best_d_reg) &&
                           ({o_kc, o_kr} < {best_kc_reg, best_kr_reg})));

    // frame gap check and persistence update
    always_comb
    begin
        frame_gt = (frame_reg > rd_last);
        gap      = frame_reg - rd_last;
        gap_lim  = (FRAME_W+1)'(cfg.max_gap_frames) + (FRAME_W+1)'(1);
        gap_ok   = frame_gt && ({1'b0, gap} <= gap_lim);
        if (!gap_ok)
        begin
            cnt_upd = PERSIST_W'(1);
        end
        else if (rd_cnt == PERSIST_MAX)
        begin
            cnt_upd = rd_cnt;
        end
        else
        begin
            cnt_upd = rd_cnt + PERSIST_W'(1);
        end
    end

    // event decision and cooldown
    always_comb
    begin
        min_p     = (cfg.min_persistence == '0) ? PERSIST_W'(1) : cfg.min_persistence;
        fire      = (cnt_reg >= min_p) && (QUIET_W'(frame_reg) >= quiet_reg);
        quiet_new = fire ? QUIET_W'(frame_reg) + QUIET_W'(cfg.cooldown_frames)
                         : quiet_reg;
    end

    // sequencer, table state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            frame_reg      <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            rsq_reg        <= '0;
            scan_idx_reg   <= '0;
            iss_vld_reg    <= 1'b0;
            iss_last_reg   <= 1'b0;
            iss_ent_reg    <= 1'b0;
            iss_idx_reg    <= '0;
            best_found_reg <= 1'b0;
            best_d_reg     <= '0;
            best_idx_reg   <= '0;
            best_kc_reg    <= '0;
            best_kr_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            slot_reg       <= '0;
            kc_reg         <= '0;
            kr_reg         <= '0;
            cnt_reg        <= '0;
            quiet_reg      <= '0;
            done_reg       <= 1'b0;
            fired_reg      <= 1'b0;
            dropped_reg    <= 1'b0;
            ev_frame_reg   <= '0;
            ev_x_reg       <= '0;
            ev_y_reg       <= '0;
            trk_x_reg      <= '0;
            trk_y_reg      <= '0;
            pers_reg       <= '0;
        end
        else
        begin
            done_reg <= 1'b0;

            // slot issue into the distance pipeline
            iss_vld_reg  <= (state_reg == S_SCAN);
            iss_last_reg <= (scan_idx_reg == LAST_IDX);
            iss_ent_reg  <= valid_reg[scan_idx_reg];
            iss_idx_reg  <= scan_idx_reg;

            // best candidate tracking
            if (cand_better)
            begin
                best_found_reg <= 1'b1;
                best_d_reg     <= d_dist;
                best_idx_reg   <= o_idx;
                best_kc_reg    <= o_kc;
                best_kr_reg    <= o_kr;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        frame_reg      <= frame_index;
                        x_reg          <= CB'(hit_x);
                        y_reg          <= CB'(hit_y);
                        rsq_reg        <= (2*RADIUS_W)'(cfg.merge_radius) *
                                          (2*RADIUS_W)'(cfg.merge_radius);
                        scan_idx_reg   <= '0;
                        best_found_reg <= 1'b0;
                        free_found_reg <= 1'b0;
                        if (operation == OP_CLEAR)
                        begin
                            valid_reg    <= '0;
                            done_reg     <= 1'b1;
                            fired_reg    <= 1'b0;
                            dropped_reg  <= 1'b0;
                            ev_frame_reg <= '0;
                            ev_x_reg     <= '0;
                            ev_y_reg     <= '0;
                            trk_x_reg    <= '0;
                            trk_y_reg    <= '0;
                            pers_reg     <= '0;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end

                S_SCAN:
                begin
                    if (!free_found_reg && !valid_reg[scan_idx_reg])
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= scan_idx_reg;
                    end
                    scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end

                S_DRAIN:
                begin
                    if (d_vld && o_last)
                    begin
                        state_reg <= S_FETCH;
                    end
                end

                S_FETCH:
                begin
                    if (best_found_reg)
                    begin
                        slot_reg  <= best_idx_reg;
                        state_reg <= S_UPD1;
                    end
                    else if (free_found_reg)
                    begin
                        slot_reg  <= free_idx_reg;
                        state_reg <= S_UPD1;
                    end
                    else
                    begin
                        // table full: drop the hit
                        done_reg     <= 1'b1;
                        fired_reg    <= 1'b0;
                        dropped_reg  <= 1'b1;
                        ev_frame_reg <= frame_reg;
                        ev_x_reg     <= OUT_COORD_W'(x_reg);
                        ev_y_reg     <= OUT_COORD_W'(y_reg);
                        trk_x_reg    <= '0;
                        trk_y_reg    <= '0;
                        pers_reg     <= '0;
                        state_reg    <= S_IDLE;
                    end
                end

                S_UPD1:
                begin
                    if (best_found_reg)
                    begin
                        kc_reg    <= rd_kc;
                        kr_reg    <= rd_kr;
                        cnt_reg   <= cnt_upd;
                        quiet_reg <= rd_quiet;
                    end
                    else
                    begin
                        // new track at the hit position
                        kc_reg    <= x_reg;
                        kr_reg    <= y_reg;
                        cnt_reg   <= PERSIST_W'(1);
                        quiet_reg <= '0;
                    end
                    state_reg <= S_UPD2;
                end

                S_UPD2:
                begin
                    valid_reg[slot_reg] <= 1'b1;
                    done_reg     <= 1'b1;
                    fired_reg    <= fire;
                    dropped_reg  <= 1'b0;
                    ev_frame_reg <= frame_reg;
                    ev_x_reg     <= OUT_COORD_W'(x_reg);
                    ev_y_reg     <= OUT_COORD_W'(y_reg);
                    trk_x_reg    <= OUT_COORD_W'(kc_reg);
                    trk_y_reg    <= OUT_COORD_W'(kr_reg);
                    pers_reg     <= cnt_reg;
                    state_reg    <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // result ports
    assign done        = done_reg;
    assign event_fired = fired_reg;
    assign event_frame = ev_frame_reg;
    assign event_x     = ev_x_reg;
    assign event_y     = ev_y_reg;
    assign track_x     = trk_x_reg;
    assign track_y     = trk_y_reg;
    assign persistence = pers_reg;
    assign dropped     = dropped_reg;

endmodule

### rtl/pdtd_cfg_regs.sv
// apb configuration registers
module pdtd_cfg_regs
    import pdtd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_persistence <= RST_MIN_PERSIST;
            cfg_reg.max_gap_frames  <= RST_MAX_GAP;
            cfg_reg.cooldown_frames <= RST_COOLDOWN;
            cfg_reg.merge_radius    <= RST_RADIUS;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MIN_PERSIST: cfg_reg.min_persistence <= pwdata[PERSIST_W-1:0];
                REG_MAX_GAP:     cfg_reg.max_gap_frames  <= pwdata[GAP_W-1:0];
                REG_COOLDOWN:    cfg_reg.cooldown_frames <= pwdata[GAP_W-1:0];
                REG_RADIUS:      cfg_reg.merge_radius    <= pwdata[RADIUS_W-1:0];
                default:         ;
            endcase
        end
    end

    // register read
    always_comb
    begin
        unique case (reg_idx)
            REG_MIN_PERSIST: prdata = APB_DATA_W'(cfg_reg.min_persistence);
            REG_MAX_GAP:     prdata = APB_DATA_W'(cfg_reg.max_gap_frames);
            REG_COOLDOWN:    prdata = APB_DATA_W'(cfg_reg.cooldown_frames);
            REG_RADIUS:      prdata = APB_DATA_W'(cfg_reg.merge_radius);
            default:         prdata = '0;
        endcase
    end

endmodule

### rtl/pdtd_track_mem.sv
// track table memory, one write port and one registered read port
module pdtd_track_mem #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 121,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/pdtd_dist_unit.sv
// three-stage squared distance pipeline, shared across all slots of a scan
module pdtd_dist_unit #(
    parameter int COORD_W = 14,
    parameter int TAG_W   = 36
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_vld,
    input  logic [TAG_W-1:0]     in_tag,
    input  logic [COORD_W-1:0]   key_col,
    input  logic [COORD_W-1:0]   key_row,
    input  logic [COORD_W-1:0]   pos_x,
    input  logic [COORD_W-1:0]   pos_y,
    output logic                 out_vld,
    output logic [TAG_W-1:0]     out_tag,
    output logic [2*COORD_W:0]   out_dist
);

    localparam int SQ_W = 2 * COORD_W;

    logic               vld1_reg, vld2_reg, vld3_reg;
    logic [TAG_W-1:0]   tag1_reg, tag2_reg, tag3_reg;
    logic [COORD_W-1:0] dx_reg, dy_reg;
    logic [SQ_W-1:0]    sqx_reg, sqy_reg;
    logic [SQ_W:0]      dist_reg;
    logic [COORD_W-1:0] dx_next, dy_next;

    // absolute differences
    always_comb
    begin
        dx_next = (key_col >= pos_x) ? key_col - pos_x : pos_x - key_col;
        dy_next = (key_row >= pos_y) ? key_row - pos_y : pos_y - key_row;
    end

    // valid flags of the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    // data path: difference, square, sum
    always_ff @(posedge clk)
    begin
        tag1_reg <= in_tag;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        tag2_reg <= tag1_reg;
        sqx_reg  <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_reg  <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        tag3_reg <= tag2_reg;
        dist_reg <= (SQ_W+1)'(sqx_reg) + (SQ_W+1)'(sqy_reg);
    end

    assign out_vld  = vld3_reg;
    assign out_tag  = tag3_reg;
    assign out_dist = dist_reg;

endmodule

### verif/testbench.sv
// self-checking testbench of the pixel defect track debouncer
`timescale 1ns / 1ps

module testbench;
    import pdtd_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int COORD_MAX = (1 << OUT_COORD_W) - 1;
    localparam int CYCLE_LIMIT = 800000;
    localparam logic OP_HIT = ~OP_CLEAR;

    typedef logic [OUT_COORD_W-1:0] coord_t;

    // one expected result of a request
    typedef struct packed {
        logic                 fired;
        logic [FRAME_W-1:0]   frame;
        coord_t               col;
        coord_t               row;
        coord_t               track_col;
        coord_t               track_row;
        logic [PERSIST_W-1:0] persist;
        logic                 dropped;
    } hit_report_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;
    logic start;
    logic busy;
    logic operation;
    logic [FRAME_W-1:0] frame_index;
    coord_t hit_x;
    coord_t hit_y;
    logic done;
    logic event_fired;
    logic [FRAME_W-1:0] event_frame;
    coord_t event_x;
    coord_t event_y;
    coord_t track_x;
    coord_t track_y;
    logic [PERSIST_W-1:0] persistence;
    logic dropped;

    // predictor copy of the track table and registers
    cfg_t track_cfg;
    logic slot_valid [TABLE_DEPTH];
    coord_t slot_col [TABLE_DEPTH];
    coord_t slot_row [TABLE_DEPTH];
    logic [FRAME_W-1:0] slot_last [TABLE_DEPTH];
    logic [PERSIST_W-1:0] slot_count [TABLE_DEPTH];
    logic [QUIET_W-1:0] slot_quiet [TABLE_DEPTH];

    hit_report_t pending_reports [$];
    int fail_count = 0;
    int cycle_count = 0;
    bit sender_idles = 1'b1;

    pixel_defect_track_debouncer #(
        .TRACK_SLOTS(TABLE_DEPTH),
        .COORD_BITS(OUT_COORD_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .start(start),
        .busy(busy),
        .operation(operation),
        .frame_index(frame_index),
        .hit_x(hit_x),
        .hit_y(hit_y),
        .done(done),
        .event_fired(event_fired),
        .event_frame(event_frame),
        .event_x(event_x),
        .event_y(event_y),
        .track_x(track_x),
        .track_y(track_y),
        .persistence(persistence),
        .dropped(dropped)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run time guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cycle_count, pending_reports.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    // nearest stored track within the merge radius, -1 when none
    function automatic int find_track_slot(coord_t x, coord_t y);
        int best;
        int i;
        longint rsq;
        longint best_dist;
        longint dx;
        longint dy;
        longint sq_dist;
        best = -1;
        if (track_cfg.merge_radius == '0)
        begin
            for (i = 0; i < TABLE_DEPTH; i++)
                if (slot_valid[i] && slot_col[i] == x && slot_row[i] == y)
                    return i;
            return -1;
        end
        rsq = longint'(track_cfg.merge_radius) * longint'(track_cfg.merge_radius);
        best_dist = rsq + 1;
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            if (!slot_valid[i])
                continue;
            dx = longint'(slot_col[i]) - longint'(x);
            dy = longint'(slot_row[i]) - longint'(y);
            sq_dist = dx * dx + dy * dy;
            if (sq_dist > rsq)
                continue;
            // ties go to the smaller column, then the smaller row
            if (sq_dist < best_dist || (sq_dist == best_dist && best >= 0 &&
                (slot_col[i] < slot_col[best] ||
                 (slot_col[i] == slot_col[best] && slot_row[i] < slot_row[best]))))
            begin
                best_dist = sq_dist;
                best = i;
            end
        end
        return best;
    endfunction

    // apply one request to the predicted table and return its result
    function automatic hit_report_t track_hit(logic op, logic [FRAME_W-1:0] frame,
                                              coord_t x, coord_t y);
        hit_report_t r;
        int s;
        int k;
        longint gap;
        logic [PERSIST_W-1:0] need;
        r = '0;
        if (op == OP_CLEAR)
        begin
            for (k = 0; k < TABLE_DEPTH; k++)
                slot_valid[k] = 1'b0;
            return r;
        end
        r.frame = frame;
        r.col = x;
        r.row = y;
        need = (track_cfg.min_persistence == '0) ? PERSIST_W'(1) : track_cfg.min_persistence;
        s = find_track_slot(x, y);
        if (s < 0)
        begin
            for (k = 0; k < TABLE_DEPTH; k++)
                if (!slot_valid[k])
                begin
                    s = k;
                    break;
                end
            // no free slot: the hit is discarded
            if (s < 0)
            begin
                r.dropped = 1'b1;
                return r;
            end
            slot_valid[s] = 1'b1;
            slot_col[s] = x;
            slot_row[s] = y;
            slot_count[s] = PERSIST_W'(1);
            slot_quiet[s] = '0;
        end
        else
        begin
            gap = longint'(frame) - longint'(slot_last[s]);
            if (gap > 0 && gap <= longint'(track_cfg.max_gap_frames) + 1)
            begin
                if (slot_count[s] != PERSIST_MAX)
                    slot_count[s] = slot_count[s] + 1'b1;
            end
            else
                slot_count[s] = PERSIST_W'(1);
        end
        slot_last[s] = frame;
        // event once persistent enough and past the cooldown
        if (slot_count[s] >= need && {1'b0, frame} >= slot_quiet[s])
        begin
            r.fired = 1'b1;
            slot_quiet[s] = {1'b0, frame} + track_cfg.cooldown_frames;
        end
        r.track_col = slot_col[s];
        r.track_row = slot_row[s];
        r.persist = slot_count[s];
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // compare each result strobe with the oldest expectation
    always @(posedge clk)
    begin : result_check
        hit_report_t want;
        if (rst_n && done)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("result with no request outstanding");
                fail_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("event_fired", want.fired, event_fired);
                check_field("event_frame", want.frame, event_frame);
                check_field("event_x", want.col, event_x);
                check_field("event_y", want.row, event_y);
                check_field("track_x", want.track_col, track_x);
                check_field("track_y", want.track_row, track_y);
                check_field("persistence", want.persist, persistence);
                check_field("dropped", want.dropped, dropped);
            end
        end
    end

    // send one request; start stays high on return so a back-to-back request can follow
    task automatic send_request(input logic op, input logic [FRAME_W-1:0] frame,
                                input coord_t x, input coord_t y);
        int gap;
        hit_report_t report;
        gap = sender_idles ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            // sometimes let the block go idle before the gap starts
            if ($urandom_range(0, 1) == 1)
                do @(posedge clk); while (busy);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        operation <= op;
        frame_index <= frame;
        hit_x <= x;
        hit_y <= y;
        do @(posedge clk); while (busy);
        report = track_hit(op, frame, x, y);
        pending_reports = {pending_reports, report};
    endtask

    task automatic send_hit(input logic [FRAME_W-1:0] frame, input int x, input int y);
        send_request(OP_HIT, frame, coord_t'(x), coord_t'(y));
    endtask

    task automatic send_clear();
        send_request(OP_CLEAR, FRAME_W'($urandom()), coord_t'($urandom()),
                     coord_t'($urandom()));
    endtask

    // hold off until every outstanding result has come back and the block is idle
    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge clk); while (pending_reports.size() != 0 || busy);
    endtask

    task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MIN_PERSIST: track_cfg.min_persistence = value[PERSIST_W-1:0];
            REG_MAX_GAP:     track_cfg.max_gap_frames = value[GAP_W-1:0];
            REG_COOLDOWN:    track_cfg.cooldown_frames = value[GAP_W-1:0];
            REG_RADIUS:      track_cfg.merge_radius = value[RADIUS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input int min_hits, input int max_gap, input int cooldown,
                                input int radius);
        wait_for_results();
        write_register(REG_MIN_PERSIST, min_hits);
        write_register(REG_MAX_GAP, max_gap);
        write_register(REG_COOLDOWN, cooldown);
        write_register(REG_RADIUS, radius);
    endtask

    function automatic coord_t clamp_coord(int v);
        if (v < 0)
            return '0;
        if (v > COORD_MAX)
            return coord_t'(COORD_MAX);
        return coord_t'(v);
    endfunction

    // frames of hits on a pool of recurring defects, with some random noise
    task automatic run_track_phase(input int items, input int pool_size, input int spread,
                                   input int jitter, input int noise_pct);
        int pool_x [80];
        int pool_y [80];
        int bx;
        int by;
        int i;
        int sent;
        logic [FRAME_W-1:0] frame;
        bx = $urandom_range(0, COORD_MAX - spread);
        by = $urandom_range(0, COORD_MAX - spread);
        for (i = 0; i < pool_size; i++)
        begin
            pool_x[i] = bx + int'($urandom_range(0, spread));
            pool_y[i] = by + int'($urandom_range(0, spread));
        end
        frame = FRAME_W'($urandom_range(0, 32'h7FFF0000));
        sent = 0;
        sender_idles = 1'b1;
        while (sent < items)
        begin
            // mostly the next frame, sometimes a repeat or a jump
            case ($urandom_range(0, 9))
                0: ;
                1: frame = frame + FRAME_W'($urandom_range(2, 6));
                default: frame = frame + 1'b1;
            endcase
            for (i = 0; i < pool_size && sent < items; i++)
            begin
                if ($urandom_range(0, 99) < 75)
                begin
                    if ($urandom_range(0, 99) < noise_pct)
                    begin
                        if ($urandom_range(0, 19) == 0)
                            send_clear();
                        else
                            send_request(OP_HIT, FRAME_W'($urandom()),
                                         coord_t'($urandom()), coord_t'($urandom()));
                    end
                    else
                        send_request(OP_HIT, frame,
                            clamp_coord(pool_x[i] + int'($urandom_range(0, 2 * jitter)) - jitter),
                            clamp_coord(pool_y[i] + int'($urandom_range(0, 2 * jitter)) - jitter));
                    sent++;
                end
            end
            if ($urandom_range(0, 49) == 0)
                wait_for_results();
            if ($urandom_range(0, 15) == 0)
                sender_idles = !sender_idles;
        end
        sender_idles = 1'b1;
    endtask

    // persistence growth and reset, frame gaps, extreme fields, clear
    task automatic test_persistence_basics();
        send_hit(10, 0, 0);
        send_hit(11, 0, 0);
        send_hit(12, 0, 0);
        send_hit(12, 0, 0);
        send_hit(11, 0, 0);
        send_hit(100, COORD_MAX, COORD_MAX);
        send_hit(102, COORD_MAX, COORD_MAX);
        send_hit(105, COORD_MAX, COORD_MAX);
        send_hit({FRAME_W{1'b1}}, COORD_MAX, 0);
        send_hit(0, 0, COORD_MAX);
        send_clear();
        send_hit(13, 0, 0);
    endtask

    // events silenced until the cooldown has run out
    task automatic test_cooldown();
        int f;
        apply_config(1, 0, 3, 0);
        for (f = 1; f <= 5; f++)
            send_hit(f, 7, 9);
    endtask

    // nearest track and distance ties under a merge radius
    task automatic test_merge_ties();
        apply_config(0, 1, 0, 0);
        send_hit(20, 310, 300);
        send_hit(20, 300, 310);
        send_hit(20, 300, 300);
        apply_config(0, 1, 0, 10);
        send_hit(21, 305, 305);
        send_hit(21, 1000, 1000);
        apply_config(0, 1, 0, 255);
        send_hit(22, 320, 320);
    endtask

    task automatic test_default_random();
        apply_config(RST_MIN_PERSIST, RST_MAX_GAP, RST_COOLDOWN, RST_RADIUS);
        run_track_phase(200, 6, 8, 0, 10);
    endtask

    task automatic test_fast_confirm();
        apply_config(1, 0, 2, 4);
        run_track_phase(150, 6, 12, 3, 10);
    endtask

    task automatic test_extreme_config();
        apply_config(65535, 65535, 65535, 255);
        run_track_phase(120, 8, 600, 40, 10);
        apply_config(0, 0, 65535, 0);
        run_track_phase(100, 5, 20, 0, 10);
    endtask

    // more live positions than slots, so hits get dropped
    task automatic test_table_full();
        apply_config(3, 1, 0, 0);
        run_track_phase(200, 72, 4000, 0, 0);
        send_clear();
    endtask

    task automatic test_random_config();
        int n;
        int radius;
        for (n = 0; n < 4; n++)
        begin
            radius = $urandom_range(0, 20);
            apply_config($urandom_range(0, 8), $urandom_range(0, 4), $urandom_range(0, 10),
                         radius);
            run_track_phase(100, $urandom_range(3, 10), 40, radius, 15);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        start <= 1'b0;
        operation <= OP_HIT;
        frame_index <= '0;
        hit_x <= '0;
        hit_y <= '0;
        track_cfg.min_persistence = RST_MIN_PERSIST;
        track_cfg.max_gap_frames = RST_MAX_GAP;
        track_cfg.cooldown_frames = RST_COOLDOWN;
        track_cfg.merge_radius = RST_RADIUS;
        for (int k = 0; k < TABLE_DEPTH; k++)
            slot_valid[k] = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_persistence_basics();
        test_cooldown();
        test_merge_ties();
        test_default_random();
        test_fast_confirm();
        test_extreme_config();
        test_table_full();
        test_random_config();

        // drain, then watch for stray results
        wait_for_results();
        repeat (2 * TABLE_DEPTH) @(posedge clk);
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
